// ===== rtl/wms_pkg.sv =====
package wms_pkg;

  // Storage and sample geometry.
  localparam int unsigned MaxElems   = 64;
  localparam int unsigned SampleBits = 16;

  // A counter that can hold the window size itself (1 .. MaxElems).
  localparam int unsigned CountBits  = $clog2(MaxElems + 1);

  // Configuration register geometry.
  localparam int unsigned CfgBits    = 4;
  localparam int unsigned CfgIdxBits = 8;
  localparam int unsigned ProdBits   = 2 * CfgBits;

  localparam logic [CfgBits-1:0] RowsReset = CfgBits'(3);
  localparam logic [CfgBits-1:0] ColsReset = CfgBits'(3);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgWindowRows = CfgIdxBits'(0),
    CfgWindowCols = CfgIdxBits'(1)
  } cfg_reg_e;

  typedef enum logic {
    StIdle,
    StDrain
  } state_e;

  typedef logic signed [SampleBits-1:0] sample_t;

  // Per-cycle command to every cell of the sorting chain.
  typedef struct packed {
    logic insert;  // insert the new sample in sorted order
    logic fresh;   // the new sample opens a window: ignore old contents
    logic shift;   // move every entry one cell toward the head
  } cell_ctrl_t;

endpackage

// ===== rtl/window_median_select.sv =====
// Median of a window of window_rows by window_cols signed samples. Samples
// enter one per beat on sample_i, in row-major order, whenever start is high
// and busy is low; while a window fills, a sample is taken in every cycle
// in which start is high. Each sample is inserted in sorted order into a
// chain of MaxElems cells in the cycle it is accepted. After the last sample
// of a window the block goes busy and shifts the sorted chain toward its head
// by (n-1)/2 cells, where n is the window size, then forms the median (for an
// even n, the two middle samples summed and halved, truncated toward zero).
// The result appears on median_o, marked by median_valid_o, which is high for
// exactly one cycle; the receiver cannot stall it, so it must take the beat
// when it is shown. busy drops in that same cycle, so the next window's first
// sample may be offered then. A size product of zero acts as a window of one;
// a product above MaxElems is clamped to MaxElems. Registers are to be
// written through the cfg channel (index 0 rows, index 1 columns, other
// indexes ignored) only while the block is idle, which the block itself
// does not enforce; cfg_ready_o is always high. If a new size is at or
// below the number of samples already held, the partial window is dropped
// and the next sample opens a fresh one.
module window_median_select (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [wms_pkg::SampleBits-1:0] sample_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wms_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [wms_pkg::CfgBits-1:0]         cfg_data_i,
  output logic                                median_valid_o,
  output logic signed [wms_pkg::SampleBits-1:0] median_o
);
  import wms_pkg::*;

  // Configuration registers.
  logic [CfgBits-1:0] rows_q, rows_d;
  logic [CfgBits-1:0] cols_q, cols_d;

  // Control state.
  state_e               state_q, state_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [CountBits-1:0] shift_q, shift_d;
  logic                 even_q, even_d;
  logic                 med_valid_q, med_valid_d;
  sample_t              med_q, med_d;

  // Window size and per-sample bookkeeping.
  logic [ProdBits-1:0]  prod;
  logic [CountBits-1:0] win_n;
  logic [CountBits-1:0] cnt_inc;
  logic                 accept;
  logic                 fresh;
  logic                 last;

  // Median arithmetic, one bit wider than a sample so the sum cannot overflow.
  logic signed [SampleBits:0] sum;
  logic signed [SampleBits:0] sum_adj;

  cell_ctrl_t ctrl;
  sample_t    head, second;

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgWindowRows: rows_d = cfg_data_i;
        CfgWindowCols: cols_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Window size: zero counts as one, anything above the chain length clamps.
  assign prod = {{(ProdBits-CfgBits){1'b0}}, rows_q} * {{(ProdBits-CfgBits){1'b0}}, cols_q};

  always_comb begin
    priority if (prod == '0) begin
      win_n = CountBits'(1);
    end else if (prod > ProdBits'(MaxElems)) begin
      win_n = CountBits'(MaxElems);
    end else begin
      win_n = prod[CountBits-1:0];
    end
  end

  assign busy    = (state_q != StIdle);
  assign accept  = start & ~busy;

  // A sample opens a new window when none is under way, or when the size
  // has shrunk to or below what the current window already holds.
  assign fresh   = (count_q == '0) || (count_q >= win_n);
  assign cnt_inc = (fresh ? '0 : count_q) + CountBits'(1);
  assign last    = (cnt_inc == win_n);

  // Odd windows add the middle sample to itself, so halving returns it as is.
  assign sum     = {head[SampleBits-1], head} +
                   (even_q ? {second[SampleBits-1], second} : {head[SampleBits-1], head});
  // Bias a negative sum by one so the halving truncates toward zero.
  assign sum_adj = sum + {{SampleBits{1'b0}}, sum[SampleBits]};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    shift_d     = shift_q;
    even_d      = even_q;
    med_d       = med_q;
    med_valid_d = 1'b0;
    ctrl        = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          ctrl.insert = 1'b1;
          ctrl.fresh  = fresh;
          if (last) begin
            // The chain is sorted at the next edge; walk the lower half out.
            count_d = '0;
            shift_d = (win_n - CountBits'(1)) >> 1;
            even_d  = ~win_n[0];
            state_d = StDrain;
          end else begin
            count_d = cnt_inc;
          end
        end
      end
      StDrain: begin
        if (shift_q != '0) begin
          ctrl.shift = 1'b1;
          shift_d    = shift_q - CountBits'(1);
        end else begin
          med_d       = sum_adj[SampleBits:1];
          med_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= RowsReset;
      cols_q      <= ColsReset;
      state_q     <= StIdle;
      count_q     <= '0;
      shift_q     <= '0;
      even_q      <= 1'b0;
      med_valid_q <= 1'b0;
    end else begin
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      state_q     <= state_d;
      count_q     <= count_d;
      shift_q     <= shift_d;
      even_q      <= even_d;
      med_valid_q <= med_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    med_q <= med_d;
  end

  // Sorting chain: one cell per possible window element.
  wms_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (sample_i),
    .head_o   (head),
    .second_o (second)
  );

  assign median_valid_o = med_valid_q;
  assign median_o       = med_q;

`ifndef SYNTHESIS
  // A result is only ever formed at the end of a drain.
  a_result_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    median_valid_o |-> $past(state_q == StDrain))
    else $error("result strobe without a preceding drain");

  // Results never come in consecutive cycles: each needs a new window.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    median_valid_o |=> !median_valid_o)
    else $error("result strobe held for more than one cycle");

  // The fill count never runs past the chain length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountBits'(MaxElems))
    else $error("sample count beyond chain length");

  // The drain never shifts further than half the chain.
  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> (shift_q <= CountBits'(MaxElems / 2)))
    else $error("drain shift count out of range");
`endif

endmodule

// ===== rtl/wms_cell.sv =====
module wms_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wms_pkg::cell_ctrl_t ctrl_i,
  input  wms_pkg::sample_t    sample_i,
  input  wms_pkg::sample_t    left_val_i,
  input  logic                left_valid_i,
  input  logic                left_gt_i,
  input  wms_pkg::sample_t    right_val_i,
  output wms_pkg::sample_t    val_o,
  output logic                valid_o,
  output logic                gt_o
);
  import wms_pkg::*;

  sample_t val_q, val_d;
  logic    valid_q, valid_d;
  logic    eff_valid;

  // An empty cell counts as holding a value above any sample.
  assign eff_valid = valid_q & ~ctrl_i.fresh;
  assign gt_o      = ~eff_valid | (val_q > sample_i);
  assign valid_o   = eff_valid;
  assign val_o     = val_q;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      // Larger entries move right; the first of them takes the sample.
      if (gt_o) begin
        val_d = left_gt_i ? left_val_i : sample_i;
      end
      valid_d = eff_valid | left_valid_i;
    end else if (ctrl_i.shift) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/wms_chain.sv =====
module wms_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wms_pkg::cell_ctrl_t ctrl_i,
  input  wms_pkg::sample_t    sample_i,
  output wms_pkg::sample_t    head_o,
  output wms_pkg::sample_t    second_o
);
  import wms_pkg::*;

  sample_t val   [MaxElems];
  logic    valid [MaxElems];
  logic    gt    [MaxElems];

  for (genvar i = 0; i < MaxElems; i++) begin : g_cell
    sample_t left_val, right_val;
    logic    left_valid, left_gt;

    if (i == 0) begin : g_head
      // The head always has room: it takes the sample whenever it is smallest.
      assign left_val   = sample_i;
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_val   = val[i-1];
      assign left_valid = valid[i-1];
      assign left_gt    = gt[i-1];
    end

    if (i == MaxElems - 1) begin : g_tail
      assign right_val = val[i];
    end else begin : g_inner
      assign right_val = val[i+1];
    end

    wms_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .sample_i     (sample_i),
      .left_val_i   (left_val),
      .left_valid_i (left_valid),
      .left_gt_i    (left_gt),
      .right_val_i  (right_val),
      .val_o        (val[i]),
      .valid_o      (valid[i]),
      .gt_o         (gt[i])
    );
  end

  assign head_o = val[0];

  if (MaxElems > 1) begin : g_second
    assign second_o = val[1];
  end else begin : g_single
    assign second_o = val[0];
  end

endmodule
